FILE: sv/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants of the escaped frame byte codec.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 4;

  // Operation codes of an input beat.
  localparam logic OP_RX = 1'b0;
  localparam logic OP_TX = 1'b1;

  // Line markers.
  localparam logic [BYTE_W-1:0] MARK_START = 8'hF0;
  localparam logic [BYTE_W-1:0] MARK_END   = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_ESC   = 8'hF5;

  typedef struct packed {
    logic              write_valid;
    logic [POS_W-1:0]  write_position;
    logic [BYTE_W-1:0] write_value;
    logic              frame_complete;
  } rx_res_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] line_byte;
    logic              frame_sent;
    logic              last_result;
  } tx_res_t;

endpackage

FILE: sv/escaped_frame_byte_codec.sv
// ----------------------------------------------------------------------------
// escaped_frame_byte_codec
// Byte-stuffed frame codec: decodes received line bytes and stuffs frame
// bytes for transmission, with an input register and a result register.
// ----------------------------------------------------------------------------
// A beat accepted into the input register passes to the result register when
// the output is free; one beat per cycle is taken unless the output stalls. A
// stuffed transmit byte holds the input register until both line bytes leave.
// Reset: synchronous, active low; clears the pipeline valids, the escape flag,
// the message position and the frame-complete flag.
module escaped_frame_byte_codec #(
  parameter int RX_LAST_POSITION = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [ebc_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_first_of_frame,
  input  logic                       in_last_of_frame,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_rx_write_valid,
  output logic [ebc_pkg::POS_W-1:0]  out_rx_write_position,
  output logic [ebc_pkg::BYTE_W-1:0] out_rx_write_value,
  output logic                       out_rx_frame_complete,
  output logic                       out_tx_valid,
  output logic [ebc_pkg::BYTE_W-1:0] out_tx_line_byte,
  output logic                       out_tx_frame_sent,
  output logic                       out_last_result
);

  logic                       iv_r;
  logic                       op_r;
  logic [ebc_pkg::BYTE_W-1:0] byte_r;
  logic                       first_r;
  logic                       last_r;
  logic                       ph_r;

  logic                       ov_r;
  ebc_pkg::rx_res_t           orx_r;
  ebc_pkg::tx_res_t           otx_r;

  ebc_pkg::rx_res_t           rx_res;
  ebc_pkg::tx_res_t           tx_res;
  logic                       two_beat;
  logic                       is_tx;
  logic                       slot_free;
  logic                       emit;
  logic                       release_item;

  assign is_tx        = (op_r == ebc_pkg::OP_TX);
  assign slot_free    = !ov_r || !out_stall;
  assign emit         = iv_r && slot_free;
  // A stuffed byte stays in the input register until its second beat leaves.
  assign release_item = emit && (!(is_tx && two_beat) || ph_r);
  assign in_stall     = iv_r && !release_item;

  ebc_rx_decode #(
    .RX_LAST_POSITION(RX_LAST_POSITION)
  ) u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .is_rx    (!is_tx),
    .commit   (emit && !is_tx),
    .data_byte(byte_r),
    .res      (rx_res)
  );

  ebc_tx_encode u_tx (
    .phase         (ph_r),
    .data_byte     (byte_r),
    .first_of_frame(first_r),
    .last_of_frame (last_r),
    .two_beat      (two_beat),
    .res           (tx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ph_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        iv_r <= in_valid;
      end
      if (release_item) begin
        ph_r <= 1'b0;
      end else if (emit) begin
        ph_r <= 1'b1;
      end
      if (slot_free) begin
        ov_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_operation;
      byte_r  <= in_data_byte;
      first_r <= in_first_of_frame;
      last_r  <= in_last_of_frame;
    end
    if (emit) begin
      if (is_tx) begin
        orx_r.write_valid    <= 1'b0;
        orx_r.write_position <= '0;
        orx_r.write_value    <= '0;
        orx_r.frame_complete <= rx_res.frame_complete;
        otx_r                <= tx_res;
      end else begin
        orx_r                <= rx_res;
        otx_r.valid          <= 1'b0;
        otx_r.line_byte      <= '0;
        otx_r.frame_sent     <= 1'b0;
        otx_r.last_result    <= 1'b1;
      end
    end
  end

  assign out_valid             = ov_r;
  assign out_rx_write_valid    = orx_r.write_valid;
  assign out_rx_write_position = orx_r.write_position;
  assign out_rx_write_value    = orx_r.write_value;
  assign out_rx_frame_complete = orx_r.frame_complete;
  assign out_tx_valid          = otx_r.valid;
  assign out_tx_line_byte      = otx_r.line_byte;
  assign out_tx_frame_sent     = otx_r.frame_sent;
  assign out_last_result       = otx_r.last_result;

endmodule

FILE: sv/ebc_rx_decode.sv
// ----------------------------------------------------------------------------
// ebc_rx_decode
// Receive side: marker and escape decoding, message position and frame state.
// ----------------------------------------------------------------------------
module ebc_rx_decode #(
  parameter int RX_LAST_POSITION = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     is_rx,
  input  logic                     commit,
  input  logic [ebc_pkg::BYTE_W-1:0] data_byte,
  output ebc_pkg::rx_res_t         res
);

  localparam int PW = $clog2(RX_LAST_POSITION + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(RX_LAST_POSITION);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          esc_r, esc_nxt;
  logic          frm_r, frm_nxt;
  logic [PW+ebc_pkg::POS_W-1:0] pos_ext;

  // The reported position is the low nibble of the internal counter.
  assign pos_ext = {{ebc_pkg::POS_W{1'b0}}, pos_r};

  always_comb begin
    pos_nxt            = pos_r;
    esc_nxt            = esc_r;
    frm_nxt            = frm_r;
    res.write_valid    = 1'b0;
    res.write_position = '0;
    res.write_value    = '0;
    if (is_rx) begin
      case (data_byte)
        ebc_pkg::MARK_START: begin
          pos_nxt = '0;
          frm_nxt = 1'b0;
          esc_nxt = 1'b0;
        end
        ebc_pkg::MARK_END: begin
          pos_nxt = '0;
          frm_nxt = 1'b1;
          esc_nxt = 1'b0;
        end
        ebc_pkg::MARK_ESC: begin
          esc_nxt = 1'b1;
        end
        default: begin
          res.write_valid    = 1'b1;
          res.write_position = pos_ext[ebc_pkg::POS_W-1:0];
          res.write_value    = esc_r ? (data_byte | ebc_pkg::MARK_START) : data_byte;
          esc_nxt            = 1'b0;
          pos_nxt            = (pos_r < LAST_POS) ? pos_r + 1'b1 : LAST_POS;
        end
      endcase
    end
    res.frame_complete = frm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      esc_r <= 1'b0;
      frm_r <= 1'b0;
    end else if (commit) begin
      pos_r <= pos_nxt;
      esc_r <= esc_nxt;
      frm_r <= frm_nxt;
    end
  end

endmodule

FILE: sv/ebc_tx_encode.sv
// ----------------------------------------------------------------------------
// ebc_tx_encode
// Transmit side: byte stuffing of inner frame bytes that look like markers.
// ----------------------------------------------------------------------------
module ebc_tx_encode (
  input  logic                       phase,
  input  logic [ebc_pkg::BYTE_W-1:0] data_byte,
  input  logic                       first_of_frame,
  input  logic                       last_of_frame,
  output logic                       two_beat,
  output ebc_pkg::tx_res_t           res
);

  logic is_mark;

  assign is_mark = (data_byte == ebc_pkg::MARK_START) ||
                   (data_byte == ebc_pkg::MARK_END) ||
                   (data_byte == ebc_pkg::MARK_ESC);

  // Opening and closing bytes of a frame are never stuffed.
  assign two_beat = is_mark && !first_of_frame && !last_of_frame;

  always_comb begin
    res.valid = 1'b1;
    if (two_beat) begin
      res.frame_sent  = 1'b0;
      res.last_result = phase;
      res.line_byte   = phase ? {4'h0, data_byte[3:0]} : ebc_pkg::MARK_ESC;
    end else begin
      res.frame_sent  = last_of_frame;
      res.last_result = 1'b1;
      res.line_byte   = data_byte;
    end
  end

endmodule

FILE: sv/ebc_checker.sv
// ----------------------------------------------------------------------------
// ebc_checker
// Port-level checks of the codec, bound to the top level.
// ----------------------------------------------------------------------------
module ebc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_rx_write_valid,
  input logic                       out_tx_valid,
  input logic [ebc_pkg::BYTE_W-1:0] out_tx_line_byte,
  input logic                       out_tx_frame_sent,
  input logic                       out_last_result
);

  // No result beat is left over from before reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result valid dropped while stalled");

  // The first beat of a stuffed byte is the escape marker.
  a_escape_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid && !out_last_result |->
      out_tx_line_byte == ebc_pkg::MARK_ESC && !out_tx_frame_sent &&
      !out_rx_write_valid)
    else $error("first beat of stuffed byte is not an escape");

  // The nibble beat follows the escape beat in the very next cycle.
  a_nibble_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_tx_valid && !out_last_result |=>
      out_valid && out_tx_valid && out_last_result &&
      out_tx_line_byte[7:4] == 4'h0 && !out_tx_frame_sent)
    else $error("stuffed byte nibble beat missing or malformed");

endmodule

bind escaped_frame_byte_codec ebc_checker u_ebc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_rx_write_valid(out_rx_write_valid),
  .out_tx_valid      (out_tx_valid),
  .out_tx_line_byte  (out_tx_line_byte),
  .out_tx_frame_sent (out_tx_frame_sent),
  .out_last_result   (out_last_result)
);

FILE: test/tb_escaped_frame_byte_codec.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_byte_codec
// Drives receive and transmit beats into the byte-stuffing codec and checks
// every result beat against a behavioral model of the decoder and encoder.
// ----------------------------------------------------------------------------
module tb_escaped_frame_byte_codec;

  localparam int          LAST_POS    = 13;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    ebc_pkg::rx_res_t rx;
    ebc_pkg::tx_res_t tx;
  } codec_res_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_operation;
  logic [ebc_pkg::BYTE_W-1:0] in_data_byte;
  logic                       in_first_of_frame;
  logic                       in_last_of_frame;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_rx_write_valid;
  logic [ebc_pkg::POS_W-1:0]  out_rx_write_position;
  logic [ebc_pkg::BYTE_W-1:0] out_rx_write_value;
  logic                       out_rx_frame_complete;
  logic                       out_tx_valid;
  logic [ebc_pkg::BYTE_W-1:0] out_tx_line_byte;
  logic                       out_tx_frame_sent;
  logic                       out_last_result;

  // Model state of the decoder.
  logic                       esc_pending;
  logic [ebc_pkg::POS_W-1:0]  rx_pos;
  logic                       frame_done;

  codec_res_t        codec_results_due[$];
  int unsigned       err_count;
  int unsigned       beats_sent;
  int unsigned       rx_beats;
  int unsigned       tx_beats;
  int unsigned       stuffed_bytes;
  int unsigned       saturated_writes;
  int unsigned       results_seen;
  int unsigned       cycle_count;
  bit                quiet;

  escaped_frame_byte_codec #(
    .RX_LAST_POSITION(LAST_POS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_data_byte         (in_data_byte),
    .in_first_of_frame    (in_first_of_frame),
    .in_last_of_frame     (in_last_of_frame),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_rx_write_valid   (out_rx_write_valid),
    .out_rx_write_position(out_rx_write_position),
    .out_rx_write_value   (out_rx_write_value),
    .out_rx_frame_complete(out_rx_frame_complete),
    .out_tx_valid         (out_tx_valid),
    .out_tx_line_byte     (out_tx_line_byte),
    .out_tx_frame_sent    (out_tx_frame_sent),
    .out_last_result      (out_last_result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic string show(codec_res_t r);
    return $sformatf("rx_wv=%0b pos=%0d val=%02h done=%0b tx_v=%0b byte=%02h sent=%0b last=%0b",
                     r.rx.write_valid, r.rx.write_position, r.rx.write_value,
                     r.rx.frame_complete, r.tx.valid, r.tx.line_byte, r.tx.frame_sent,
                     r.tx.last_result);
  endfunction

  function automatic bit is_marker(logic [ebc_pkg::BYTE_W-1:0] b);
    return (b == ebc_pkg::MARK_START) || (b == ebc_pkg::MARK_END) ||
           (b == ebc_pkg::MARK_ESC);
  endfunction

  // Works out the result beats of one accepted input beat and queues them.
  task automatic predict_codec_beat(logic op, logic [ebc_pkg::BYTE_W-1:0] b, logic is_first,
                                    logic is_last);
    codec_res_t r;
    r = '0;
    if (op == ebc_pkg::OP_RX) begin
      rx_beats++;
      if (b == ebc_pkg::MARK_START) begin
        rx_pos      = '0;
        frame_done  = 1'b0;
        esc_pending = 1'b0;
      end else if (b == ebc_pkg::MARK_END) begin
        rx_pos      = '0;
        frame_done  = 1'b1;
        esc_pending = 1'b0;
      end else if (b == ebc_pkg::MARK_ESC) begin
        esc_pending = 1'b1;
      end else begin
        r.rx.write_valid    = 1'b1;
        r.rx.write_position = rx_pos;
        r.rx.write_value    = esc_pending ? (b | ebc_pkg::MARK_START) : b;
        esc_pending         = 1'b0;
        if (rx_pos < LAST_POS) rx_pos = rx_pos + 1'b1;
        else saturated_writes++;
      end
      r.rx.frame_complete = frame_done;
      r.tx.last_result    = 1'b1;
      codec_results_due.push_back(r);
    end else begin
      tx_beats++;
      r.rx.frame_complete = frame_done;
      r.tx.valid          = 1'b1;
      if (!is_first && !is_last && is_marker(b)) begin
        stuffed_bytes++;
        r.tx.line_byte = ebc_pkg::MARK_ESC;
        codec_results_due.push_back(r);
        r.tx.line_byte   = {4'h0, b[3:0]};
        r.tx.last_result = 1'b1;
        codec_results_due.push_back(r);
      end else begin
        r.tx.line_byte   = b;
        r.tx.frame_sent  = is_last;
        r.tx.last_result = 1'b1;
        codec_results_due.push_back(r);
      end
    end
  endtask

  // Presents one beat, waits for it to be taken, then maybe idles.
  task automatic send_beat(logic op, logic [ebc_pkg::BYTE_W-1:0] b, logic is_first = 1'b0,
                           logic is_last = 1'b0);
    int unsigned idle;
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_data_byte      <= b;
    in_first_of_frame <= is_first;
    in_last_of_frame  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_codec_beat(op, b, is_first, is_last);
    beats_sent++;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    idle = quiet ? 0 : gap_len();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Receiver side back-pressure.
  always @(posedge clk) begin
    int unsigned hold;
    if (hold == 0) begin
      out_stall <= !quiet && ($urandom_range(0, 2) == 0);
      hold = gap_len();
    end else begin
      hold--;
    end
  end

  always @(posedge clk) begin
    codec_res_t got;
    codec_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.rx.write_valid    = out_rx_write_valid;
      got.rx.write_position = out_rx_write_position;
      got.rx.write_value    = out_rx_write_value;
      got.rx.frame_complete = out_rx_frame_complete;
      got.tx.valid          = out_tx_valid;
      got.tx.line_byte      = out_tx_line_byte;
      got.tx.frame_sent     = out_tx_frame_sent;
      got.tx.last_result    = out_last_result;
      results_seen++;
      if (codec_results_due.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("Unexpected result beat: %s", show(got));
      end else begin
        want = codec_results_due.pop_front();
        if (got.rx.write_valid !== want.rx.write_valid ||
            got.rx.write_position !== want.rx.write_position ||
            got.rx.write_value !== want.rx.write_value ||
            got.rx.frame_complete !== want.rx.frame_complete ||
            got.tx.valid !== want.tx.valid ||
            got.tx.line_byte !== want.tx.line_byte ||
            got.tx.frame_sent !== want.tx.frame_sent ||
            got.tx.last_result !== want.tx.last_result) begin
          err_count++;
          if (err_count <= 10) begin
            $display("Mismatch at result %0d", results_seen);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", codec_results_due.size());
      $display("[escaped_frame_byte_codec] ERROR");
      $finish;
    end
  end

  task automatic test_rx_directed();
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_START);
    send_beat(ebc_pkg::OP_RX, 8'h00);
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
    send_beat(ebc_pkg::OP_RX, 8'h0A);
    // A second escape keeps the first one pending.
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
    send_beat(ebc_pkg::OP_RX, 8'h03);
    // Start and end markers both drop a pending escape.
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_START);
    send_beat(ebc_pkg::OP_RX, 8'h7F);
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
    send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_END);
    send_beat(ebc_pkg::OP_RX, 8'h01);
  endtask

  task automatic test_tx_directed();
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_START, 1'b1, 1'b0);
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_START, 1'b0, 1'b0);
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_END, 1'b0, 1'b0);
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_ESC, 1'b0, 1'b0);
    send_beat(ebc_pkg::OP_TX, 8'h00, 1'b0, 1'b0);
    send_beat(ebc_pkg::OP_TX, 8'hF1, 1'b0, 1'b0);
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_END, 1'b0, 1'b1);
    send_beat(ebc_pkg::OP_TX, ebc_pkg::MARK_ESC, 1'b1, 1'b1);
  endtask

  // Well-formed stuffed frames, with the odd frame missing its end marker.
  task automatic test_rx_frames(int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    logic [ebc_pkg::BYTE_W-1:0] b;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_START, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14) : $urandom_range(15, 20);
      repeat (n) begin
        if ($urandom_range(0, 99) < 20) begin
          send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_ESC);
          send_beat(ebc_pkg::OP_RX, 8'($urandom_range(0, 15)));
        end else begin
          b = 8'($urandom_range(0, 255));
          if (is_marker(b)) b[0] = ~b[0];
          send_beat(ebc_pkg::OP_RX, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 9) != 0) send_beat(ebc_pkg::OP_RX, ebc_pkg::MARK_END);
    end
  endtask

  function automatic logic [ebc_pkg::BYTE_W-1:0] tx_payload();
    case ($urandom_range(0, 7))
      0: return ebc_pkg::MARK_START;
      1: return ebc_pkg::MARK_END;
      2: return ebc_pkg::MARK_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_tx_frames(int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(ebc_pkg::OP_TX, tx_payload(), 1'b1, 1'b1);
      end else begin
        send_beat(ebc_pkg::OP_TX, tx_payload(), 1'b1, 1'b0);
        n = $urandom_range(0, 12);
        repeat (n) send_beat(ebc_pkg::OP_TX, tx_payload(), 1'b0, 1'b0);
        send_beat(ebc_pkg::OP_TX, tx_payload(), 1'b0, 1'b1);
      end
    end
  endtask

  task automatic test_mixed_noise(int unsigned target);
    repeat (target) begin
      send_beat(1'($urandom_range(0, 1)), tx_payload(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_operation      <= ebc_pkg::OP_RX;
    in_data_byte      <= '0;
    in_first_of_frame <= 1'b0;
    in_last_of_frame  <= 1'b0;
    esc_pending = 1'b0;
    rx_pos      = '0;
    frame_done  = 1'b0;
    quiet       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rx_directed();
    test_tx_directed();
    test_rx_frames(200);
    test_tx_frames(200);
    test_mixed_noise(100);

    in_valid <= 1'b0;
    while (codec_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d beats (%0d receive, %0d transmit) and checked %0d result beats.",
             beats_sent, rx_beats, tx_beats, results_seen);
    $display("Stuffed %0d transmit bytes, saw %0d writes at the last position, %0d errors.",
             stuffed_bytes, saturated_writes, err_count);
    if (err_count == 0 && codec_results_due.size() == 0) begin
      $display("[escaped_frame_byte_codec] OK");
    end else begin
      $display("[escaped_frame_byte_codec] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ebc_pkg.sv
sv/ebc_rx_decode.sv
sv/ebc_tx_encode.sv
sv/escaped_frame_byte_codec.sv
sv/ebc_checker.sv
test/tb_escaped_frame_byte_codec.sv
